// File: src/board_keyed_chained_hash_map_assert.svh
// assertion macros for the hash map block
`ifndef BOARD_KEYED_CHAINED_HASH_MAP_ASSERT_SVH
`define BOARD_KEYED_CHAINED_HASH_MAP_ASSERT_SVH
// implication checked every clock outside reset
`define BKH_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
// next-cycle implication checked outside reset
`define BKH_ASSERT_NEXT(label, clk, rst_n, a, c, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`endif

// File: src/bkh_pkg.sv
// package of the hash map block: sizes, status codes, states
package bkh_pkg;
	localparam int BUCKETS = 1024;
	localparam int POOL_ENTRIES = 4096;
	localparam int BW = $clog2(BUCKETS);
	localparam int EW = $clog2(POOL_ENTRIES);
	localparam int CW = $clog2(POOL_ENTRIES + 1);

	localparam logic [2:0] ST_GET_HIT = 3'd0;
	localparam logic [2:0] ST_GET_MISS = 3'd1;
	localparam logic [2:0] ST_PUT_UPDATED = 3'd2;
	localparam logic [2:0] ST_PUT_INSERTED = 3'd3;
	localparam logic [2:0] ST_PUT_DROPPED = 3'd4;

	typedef enum logic [6:0] {
		S_CLR  = 7'b0000001,
		S_IDLE = 7'b0000010,
		S_HEAD = 7'b0000100,
		S_RD   = 7'b0001000,
		S_CMP  = 7'b0010000,
		S_INS  = 7'b0100000,
		S_OUT  = 7'b1000000
	} state_t;
endpackage

// File: src/board_keyed_chained_hash_map.sv
// top level of the board keyed chained hash map
// Usage: one input item (func, black_bits, white_bits, store_value) is taken
// on in_valid && in_ready; one result (status, found_value) leaves on
// out_valid && out_ready.  The block handles one item at a time.
// Bucket = (black_bits + white_bits) mod BUCKETS.  The head table is read
// in S_HEAD, then each chain entry visited takes an S_RD state (memory
// read) and an S_CMP state (key compare), at least one pair even for an
// empty bucket, plus an S_INS state for an insert.  The registered read
// port of the entry pool is why read and compare are separate states.
// The result sits in an output register; while the receiver stalls the
// block holds it and takes no new item.
// After reset a clearing pass writes every head table entry empty, one per
// cycle, and the block is not ready until the pass ends; the pool count
// is cleared at once and pool entries stay undefined until written.
// Dropped puts (pool full) report status 4 and change nothing.
module board_keyed_chained_hash_map import bkh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              func,
	input  logic [63:0]       black_bits,
	input  logic [63:0]       white_bits,
	input  logic signed [7:0] store_value,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        status,
	output logic signed [7:0] found_value
);
`include "board_keyed_chained_hash_map_assert.svh"

	state_t state_q;
	logic func_q;
	logic [63:0] kb_q, kw_q;
	logic [7:0] val_q;
	logic [BW-1:0] bkt_q;
	logic [BW-1:0] clr_q;
	logic [EW:0] bhead_mem [BUCKETS];
	logic [EW:0] head_rd_q;
	logic [63:0] eb_mem [POOL_ENTRIES];
	logic [63:0] ew_mem [POOL_ENTRIES];
	logic [7:0] ev_mem [POOL_ENTRIES];
	logic [EW:0] el_mem [POOL_ENTRIES];
	logic [63:0] rb_q, rw_q;
	logic [7:0] rv_q;
	logic [EW:0] rl_q;
	logic cur_valid_q;
	logic [EW-1:0] idx_q;
	logic [EW-1:0] rd_idx;
	logic [CW-1:0] used_q, steps_q;
	logic [2:0] status_q;
	logic [7:0] found_q;
	logic [63:0] ksum;
	logic hit;

	assign ksum = black_bits + white_bits;
	assign hit = (rb_q == kb_q) && (rw_q == kw_q);
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status = status_q;
	assign found_value = found_q;
	// first read of a walk goes to the bucket head, later ones follow links
	assign rd_idx = (steps_q == '0) ? head_rd_q[EW-1:0] : idx_q;

	// head table clear, read and write (valid bit on top of the index)
	always_ff @(posedge clk) begin
		if (state_q == S_CLR) bhead_mem[clr_q] <= '0;
		if (state_q == S_HEAD) head_rd_q <= bhead_mem[bkt_q];
		if (state_q == S_INS) bhead_mem[bkt_q] <= {1'b1, used_q[EW-1:0]};
	end

	// pool read and write
	always_ff @(posedge clk) begin
		if (state_q == S_RD) begin
			rb_q <= eb_mem[rd_idx];
			rw_q <= ew_mem[rd_idx];
			rv_q <= ev_mem[rd_idx];
			rl_q <= el_mem[rd_idx];
		end
		if (state_q == S_INS) begin
			eb_mem[used_q[EW-1:0]] <= kb_q;
			ew_mem[used_q[EW-1:0]] <= kw_q;
			ev_mem[used_q[EW-1:0]] <= val_q;
			el_mem[used_q[EW-1:0]] <= head_rd_q;
		end
		if (state_q == S_CMP && hit && func_q) ev_mem[idx_q] <= val_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			used_q <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BW'(BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_valid) begin
					func_q <= func;
					kb_q <= black_bits;
					kw_q <= white_bits;
					val_q <= store_value;
					bkt_q <= ksum[BW-1:0];
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					steps_q <= '0;
					cur_valid_q <= 1'b1;
					state_q <= S_RD;
				end
				S_RD: begin
					if (steps_q == '0) begin
						cur_valid_q <= head_rd_q[EW];
						idx_q <= head_rd_q[EW-1:0];
					end
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (cur_valid_q && steps_q < used_q && hit) begin
						status_q <= func_q ? ST_PUT_UPDATED : ST_GET_HIT;
						found_q <= func_q ? 8'd0 : rv_q;
						state_q <= S_OUT;
					end else if (cur_valid_q && steps_q < used_q && rl_q[EW]) begin
						cur_valid_q <= 1'b1;
						idx_q <= rl_q[EW-1:0];
						steps_q <= steps_q + 1'b1;
						state_q <= S_RD;
					end else begin
						found_q <= 8'd0;
						if (!func_q) begin
							status_q <= ST_GET_MISS;
							state_q <= S_OUT;
						end else if (used_q >= CW'(POOL_ENTRIES)) begin
							status_q <= ST_PUT_DROPPED;
							state_q <= S_OUT;
						end else begin
							status_q <= ST_PUT_INSERTED;
							state_q <= S_INS;
						end
					end
				end
				S_INS: begin
					used_q <= used_q + 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// on the first read of a walk and on each compare the step count must not exceed the pool count
	wire rd_first = (state_q == S_RD) && (steps_q == '0);
	`BKH_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, used_q <= CW'(POOL_ENTRIES), "pool count over")
	`BKH_ASSERT_NEXT(a_ins_out, clk, arst_n, state_q == S_INS, state_q == S_OUT, "insert not final")
	`BKH_ASSERT_NEXT(a_ins_count, clk, arst_n, state_q == S_INS, used_q == $past(used_q) + 1'b1, "count not bumped")
	`BKH_ASSERT_IMP(a_steps, clk, arst_n, rd_first || state_q == S_CMP, steps_q <= used_q, "walk too long")
endmodule

// File: tb/sv/board_keyed_chained_hash_map_chk.sv
// checker for the board keyed hash map: predicts every result and compares it
module board_keyed_chained_hash_map_chk import bkh_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  logic              func,
	input  logic [63:0]       black_bits,
	input  logic [63:0]       white_bits,
	input  logic signed [7:0] store_value,
	input  logic              out_valid,
	input  logic              out_ready,
	input  logic [2:0]        status,
	input  logic signed [7:0] found_value,
	output int                mismatches,
	output int                awaited,
	output int                checked,
	output int                drops_seen,
	output int                hits_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_GET = 1'b0;

	typedef struct packed {
		logic [2:0]        st;
		logic signed [7:0] val;
	} map_result_t;

	// shadow copy of the map
	logic              head_ok  [BUCKETS];
	int                head_idx [BUCKETS];
	logic [63:0]       key_b    [POOL_ENTRIES];
	logic [63:0]       key_w    [POOL_ENTRIES];
	logic signed [7:0] held_val [POOL_ENTRIES];
	logic              next_ok  [POOL_ENTRIES];
	int                next_idx [POOL_ENTRIES];
	int                used;

	map_result_t results_due[$];

	assign awaited = results_due.size();

	// apply one get or put to the shadow map and return its result
	function automatic map_result_t apply_op(logic op, logic [63:0] kb, logic [63:0] kw,
			logic signed [7:0] v);
		map_result_t r;
		logic [63:0] sum;
		int bkt;
		int idx;
		int steps;
		logic ok;
		logic hit;
		sum = kb + kw;
		bkt = int'(sum % BUCKETS);
		ok = head_ok[bkt];
		idx = head_idx[bkt];
		steps = 0;
		hit = 1'b0;
		r.val = '0;
		// chain walk, bounded by the pool count
		while (ok && idx < POOL_ENTRIES && steps < used && !hit) begin
			if (key_b[idx] == kb && key_w[idx] == kw)
				hit = 1'b1;
			else begin
				ok = next_ok[idx];
				idx = next_idx[idx];
				steps++;
			end
		end
		if (op == OP_GET) begin
			if (hit) begin
				r.st = ST_GET_HIT;
				r.val = held_val[idx];
			end else
				r.st = ST_GET_MISS;
		end else if (hit) begin
			held_val[idx] = v;
			r.st = ST_PUT_UPDATED;
		end else if (used >= POOL_ENTRIES) begin
			r.st = ST_PUT_DROPPED;
		end else begin
			key_b[used] = kb;
			key_w[used] = kw;
			held_val[used] = v;
			next_ok[used] = head_ok[bkt];
			next_idx[used] = head_idx[bkt];
			head_ok[bkt] = 1'b1;
			head_idx[bkt] = used;
			used++;
			r.st = ST_PUT_INSERTED;
		end
		return r;
	endfunction

	// clear under reset, predict on accepted input items, compare on accepted results
	always @(posedge clk) begin
		map_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS; i++) begin
				head_ok[i] = 1'b0;
				head_idx[i] = 0;
			end
			used = 0;
			mismatches = 0;
			checked = 0;
			drops_seen = 0;
			hits_seen = 0;
			results_due.delete();
		end else begin
			if (in_valid && in_ready)
				results_due.push_back(apply_op(func, black_bits, white_bits, store_value));
			if (out_valid && out_ready) begin
				checked++;
				if (status == ST_PUT_DROPPED) drops_seen++;
				if (status == ST_GET_HIT) hits_seen++;
				if (results_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result with nothing pending: status %0d value %0d",
							status, found_value);
				end else begin
					want = results_due.pop_front();
					if (status !== want.st || found_value !== want.val) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: status exp %0d got %0d, value exp %0d got %0d",
								want.st, status, want.val, found_value);
					end
				end
			end
		end
	end
endmodule

// File: tb/sv/board_keyed_chained_hash_map_tb.sv
// testbench top for the board keyed hash map: stimulus, watchdog and verdict
module board_keyed_chained_hash_map_tb import bkh_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;
	localparam int   STALL_LIMIT = 100000;
	localparam int   KEYSET = 48;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              func = OP_GET;
	logic [63:0]       black_bits = '0;
	logic [63:0]       white_bits = '0;
	logic signed [7:0] store_value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [2:0]        status;
	logic signed [7:0] found_value;

	int mismatches, awaited, checked, drops_seen, hits_seen;
	int sent = 0;
	int quiet_cycles = 0;
	logic no_idle = 1'b0;

	logic [63:0] ks_b [KEYSET];
	logic [63:0] ks_w [KEYSET];

	always #5 clk = ~clk;

	board_keyed_chained_hash_map dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .black_bits(black_bits), .white_bits(white_bits),
		.store_value(store_value), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_value(found_value)
	);

	board_keyed_chained_hash_map_chk chk (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.func(func), .black_bits(black_bits), .white_bits(white_bits),
		.store_value(store_value), .out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found_value(found_value), .mismatches(mismatches),
		.awaited(awaited), .checked(checked), .drops_seen(drops_seen),
		.hits_seen(hits_seen)
	);

	// receiver stalls at random unless idling is switched off
	always @(posedge clk) begin
		out_ready <= no_idle ? 1'b1 : ($urandom_range(99) >= 12);
	end

	// watchdog on cycles without any accepted item
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[board_keyed_chained_hash_map] ERROR");
			$finish;
		end
	end

	// present one item and hold it until accepted
	task automatic send_op(logic op, logic [63:0] kb, logic [63:0] kw, logic signed [7:0] v);
		if (!no_idle && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= op;
		black_bits <= kb;
		white_bits <= kw;
		store_value <= v;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (awaited != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	logic [63:0] rb, rw;
	int k;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty map, extreme keys and values, minus one as a value
		send_op(OP_GET, '0, '0, 8'sd5);
		send_op(OP_PUT, '0, '0, -8'sd128);
		send_op(OP_GET, '0, '0, '0);
		send_op(OP_GET, '1, '1, '0);
		send_op(OP_PUT, '1, '1, 8'sd127);
		send_op(OP_GET, '1, '1, '0);
		send_op(OP_PUT, '1, '1, -8'sd1);
		send_op(OP_GET, '1, '1, 8'sd99);
		// same bucket sum, different keys, walking a chain
		send_op(OP_PUT, 64'd1, '1, 8'sd7);
		send_op(OP_PUT, '1, 64'd1, 8'sd8);
		send_op(OP_GET, 64'd1, '1, '0);
		send_op(OP_GET, '1, 64'd1, '0);
		send_op(OP_GET, 64'd2, '1 - 64'd1, '0);
		send_op(OP_PUT, '0, '0, 8'sd0);
		send_op(OP_GET, '0, '0, '0);
		send_op(OP_GET, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, '0);
		drain();

		// key set crowded into few buckets so chains get long
		for (int i = 0; i < KEYSET; i++) begin
			ks_b[i] = {$urandom, $urandom};
			ks_w[i] = 64'(i % 4) * 64'd257 - ks_b[i] + {$urandom, 22'd0, 10'd0};
		end

		// random mix, mostly keys from the set
		for (int n = 0; n < 720; n++) begin
			no_idle = (n >= 300 && n < 420);
			if (n == 500) drain();
			if ($urandom_range(99) < 85) begin
				k = $urandom_range(KEYSET - 1);
				rb = ks_b[k];
				rw = ks_w[k];
			end else begin
				rb = {$urandom, $urandom};
				rw = {$urandom, $urandom};
			end
			send_op(1'($urandom), rb, rw, 8'($urandom));
		end
		no_idle = 1'b0;
		drain();

		// tail mix of fresh keys and set keys
		for (int n = 0; n < 60; n++) begin
			k = $urandom_range(KEYSET - 1);
			case ($urandom_range(3))
				0: send_op(OP_PUT, {$urandom, $urandom}, {$urandom, $urandom}, 8'($urandom));
				1: send_op(OP_PUT, ks_b[k], ks_w[k], 8'($urandom));
				2: send_op(OP_GET, ks_b[k], ks_w[k], 8'($urandom));
				default: send_op(OP_GET, {$urandom, $urandom}, {$urandom, $urandom}, '0);
			endcase
		end
		drain();

		$display("sent %0d items, checked %0d results (%0d get hits, %0d dropped puts)",
			sent, checked, hits_seen, drops_seen);
		$display("covered empty map, chained buckets, updates and stalled receivers");
		if (mismatches == 0 && awaited == 0)
			$display("[board_keyed_chained_hash_map] OK");
		else
			$display("[board_keyed_chained_hash_map] ERROR");
		$finish;
	end
endmodule
